// File: rtl/core/pusag_pkg.sv
// Shared types, sizes and codes of the shifted-gather address generator.
package pusag_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int SHIFT_DEPTH = 1024;
    localparam int ADDR_BITS   = 32;

    localparam int DIM_W   = 3;
    localparam int AX_W    = 2;
    localparam int EXT_W   = 16;
    localparam int IDX_W   = 10;
    localparam int SHIFT_W = 17;
    localparam int TBL_W   = SHIFT_W + 1;
    localparam int TBL_AW  = $clog2(SHIFT_DEPTH);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(3);

    localparam logic [EXT_W:0]  DEPTH_LIMIT = (EXT_W + 1)'(SHIFT_DEPTH);
    localparam logic [63:0]     COUNT_LIMIT = 64'(1) << ADDR_BITS;
    localparam logic [TBL_W-1:0] TBL_MISSING = {1'b1, {SHIFT_W{1'b0}}};

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_NUM_DIMS   = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_DIM_SIZE_0 = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_DIM_SIZE_1 = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_DIM_SIZE_2 = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] CFG_DIM_SIZE_3 = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] CFG_SHIFT_AXIS = CFG_AW'(5);
    localparam logic [CFG_AW-1:0] CFG_UNIT_AXIS  = CFG_AW'(6);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               restart;
        logic [IDX_W-1:0]   tindex;
        logic [SHIFT_W-1:0] shift;
        logic               missing;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0]                  num_dims;
        logic [MAX_DIMS-1:0][EXT_W-1:0]    size;
        logic [AX_W-1:0]                   shift_axis;
        logic [AX_W-1:0]                   unit_axis;
        logic                              bad;
        logic [ADDR_BITS-1:0]              stride_cand;
    } t_cfg;

endpackage

// File: rtl/core/pusag_cfg.sv
// Configuration registers with pipelined stride and error derivation.
module pusag_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pusag_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [pusag_pkg::CFG_DW-1:0]  i_cfg_wdata,
    output pusag_pkg::t_cfg               o_cfg,
    output logic                          o_busy
);
    import pusag_pkg::*;

    logic [DIM_W-1:0]               r_num_dims;
    logic [MAX_DIMS-1:0][EXT_W-1:0] r_size;
    logic [AX_W-1:0]                r_shift_axis;
    logic [AX_W-1:0]                r_unit_axis;
    logic [SETTLE_W-1:0]            r_settle;

    logic [ADDR_BITS-1:0] r_s2;
    logic [ADDR_BITS-1:0] r_s3;
    logic [31:0]          r_p01;
    logic [31:0]          r_p23;
    logic                 r_flag1;
    logic [63:0]          r_cnt;
    logic                 r_flag2;
    logic                 r_bad;

    logic [MAX_DIMS-1:0][EXT_W-1:0] used_ext;
    logic                           flag_now;
    logic [ADDR_BITS-1:0]           cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= DIM_W'(2);
            r_size       <= {MAX_DIMS{EXT_W'(1)}};
            r_shift_axis <= AX_W'(1);
            r_unit_axis  <= AX_W'(0);
            r_settle     <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_we) begin
                r_settle <= SETTLE_CYCLES;
                unique case (i_cfg_addr)
                    CFG_NUM_DIMS:   r_num_dims   <= i_cfg_wdata[DIM_W-1:0];
                    CFG_DIM_SIZE_0: r_size[0]    <= i_cfg_wdata[EXT_W-1:0];
                    CFG_DIM_SIZE_1: r_size[1]    <= i_cfg_wdata[EXT_W-1:0];
                    CFG_DIM_SIZE_2: r_size[2]    <= i_cfg_wdata[EXT_W-1:0];
                    CFG_DIM_SIZE_3: r_size[3]    <= i_cfg_wdata[EXT_W-1:0];
                    CFG_SHIFT_AXIS: r_shift_axis <= i_cfg_wdata[AX_W-1:0];
                    CFG_UNIT_AXIS:  r_unit_axis  <= i_cfg_wdata[AX_W-1:0];
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
        end
    end

    // Extents of unused dimensions count as one; zero extents only matter in use
    always_comb begin
        flag_now = (r_num_dims < DIM_W'(1)) || (r_num_dims > DIM_W'(MAX_DIMS)) ||
                   ({1'b0, r_shift_axis} >= r_num_dims) ||
                   ({1'b0, r_unit_axis} >= r_num_dims) ||
                   (r_shift_axis == r_unit_axis);
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (DIM_W'(d) < r_num_dims) begin
                used_ext[d] = r_size[d];
                if (r_size[d] == '0) flag_now = 1'b1;
            end else begin
                used_ext[d] = EXT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2    <= ADDR_BITS'(r_size[0]) * ADDR_BITS'(r_size[1]);
        r_s3    <= r_s2 * ADDR_BITS'(r_size[2]);
        r_p01   <= 32'(used_ext[0]) * 32'(used_ext[1]);
        r_p23   <= 32'(used_ext[2]) * 32'(used_ext[3]);
        r_flag1 <= flag_now;
        r_cnt   <= 64'(r_p01) * 64'(r_p23);
        r_flag2 <= r_flag1;
        r_bad   <= r_flag2 || (r_cnt > COUNT_LIMIT);
    end

    always_comb begin
        case (r_shift_axis)
            2'd0:    cand = ADDR_BITS'(1);
            2'd1:    cand = ADDR_BITS'(r_size[0]);
            2'd2:    cand = r_s2;
            default: cand = r_s3;
        endcase
    end

    assign o_cfg.num_dims    = r_num_dims;
    assign o_cfg.size        = r_size;
    assign o_cfg.shift_axis  = r_shift_axis;
    assign o_cfg.unit_axis   = r_unit_axis;
    assign o_cfg.bad         = r_bad;
    assign o_cfg.stride_cand = cand;
    assign o_busy            = (r_settle != '0);

endmodule

// File: rtl/core/pusag_front.sv
// Input side: accepts and decodes stream items into a short queue.
module pusag_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // restart[0], table_index[10:1], shift_amount[27:11], shift_missing[28], zero pad
    input  logic [31:0]      i_s_axis_tdata,
    // kind[0]
    input  logic             i_s_axis_tuser,
    input  logic             i_hold,
    output logic             o_head_valid,
    output pusag_pkg::t_item o_head,
    input  logic             i_pop
);
    import pusag_pkg::*;

    t_item            r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_AW:0]    r_cnt;

    t_item item;
    logic  push;

    always_comb begin
        item.kind    = t_kind'(i_s_axis_tuser);
        item.restart = i_s_axis_tdata[0];
        item.tindex  = i_s_axis_tdata[10:1];
        item.shift   = i_s_axis_tdata[27:11];
        item.missing = i_s_axis_tdata[28];
    end

    assign o_s_axis_tready = (r_cnt != (Q_AW + 1)'(Q_DEPTH)) && !i_hold;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop) r_rp <= r_rp + Q_AW'(1);
            if (push && !i_pop) r_cnt <= r_cnt + (Q_AW + 1)'(1);
            else if (!push && i_pop) r_cnt <= r_cnt - (Q_AW + 1)'(1);
        end
    end

    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

endmodule

// File: rtl/core/pusag_back.sv
// Work side: shift table, coordinate walk and the address pipeline.
module pusag_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pusag_pkg::t_cfg  i_cfg,
    input  logic             i_head_valid,
    input  pusag_pkg::t_item i_head,
    output logic             o_pop,
    output logic             o_tbl_busy,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // out_index[31:0], source_address[63:32]
    output logic [63:0]      o_m_axis_tdata,
    // fill[0], config_error[1]
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import pusag_pkg::*;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lin;
        logic [ADDR_BITS-1:0] stride;
        logic [EXT_W-1:0]     scoord;
        logic [EXT_W-1:0]     sext;
        logic                 unit_ok;
        logic                 bad;
        logic                 last;
    } t_stage_b;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lin;
        logic [ADDR_BITS-1:0] prod;
        logic                 fill;
        logic                 bad;
        logic                 last;
    } t_stage_c;

    // Shift table, cleared to missing by a sweep after reset
    logic [TBL_W-1:0]  r_tbl [SHIFT_DEPTH];
    logic [TBL_W-1:0]  r_rd;
    logic              r_clr_busy;
    logic [TBL_AW-1:0] r_clr_idx;

    logic [MAX_DIMS-1:0][EXT_W-1:0] r_coord;
    logic [ADDR_BITS-1:0]           r_lin;
    logic [ADDR_BITS-1:0]           r_stride;

    t_stage_b r_b;
    t_stage_c r_c;
    logic     r_b_valid;
    logic     r_c_valid;
    logic     r_o_valid;
    logic [ADDR_BITS-1:0] r_o_index;
    logic [ADDR_BITS-1:0] r_o_src;
    logic                 r_o_fill;
    logic                 r_o_err;
    logic                 r_o_last;

    logic out_free, c_free, b_free;
    logic load_fire, step_fire;

    logic [MAX_DIMS-1:0][EXT_W-1:0] coord_eff;
    logic [MAX_DIMS-1:0][EXT_W-1:0] coord_step;
    logic [MAX_DIMS-1:0][EXT_W-1:0] n_coord;
    logic [ADDR_BITS-1:0]           lin_eff;
    logic [ADDR_BITS-1:0]           n_lin;
    logic [ADDR_BITS-1:0]           stride_eff;
    logic [EXT_W-1:0]               ucoord;
    logic                           unit_ok;
    logic                           is_last;
    logic                           carry;
    t_stage_b                       b_next;

    logic                              missing_b;
    logic signed [SHIFT_W-1:0]         sh;
    logic signed [EXT_W+2:0]           nt;
    logic                              in_range;
    logic [ADDR_BITS-1:0]              prod_lo;
    t_stage_c                          c_next;

    assign out_free  = !r_o_valid || i_m_axis_tready;
    assign c_free    = !r_c_valid || out_free;
    assign b_free    = !r_b_valid || c_free;
    assign load_fire = i_head_valid && (i_head.kind == KIND_LOAD) && !r_clr_busy;
    assign step_fire = i_head_valid && (i_head.kind == KIND_STEP) && !r_clr_busy && b_free;
    assign o_pop     = load_fire || step_fire;

    // Walk stage: apply restart, pick the table entry, advance the coordinates
    always_comb begin
        lin_eff    = i_head.restart ? '0 : r_lin;
        stride_eff = i_head.restart ? i_cfg.stride_cand : r_stride;
        for (int d = 0; d < MAX_DIMS; d++) begin
            coord_eff[d] = i_head.restart ? '0 : r_coord[d];
        end
        ucoord  = coord_eff[i_cfg.unit_axis];
        unit_ok = {1'b0, ucoord} < DEPTH_LIMIT;

        is_last = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if ((DIM_W'(d) < i_cfg.num_dims) &&
                (({1'b0, coord_eff[d]} + (EXT_W + 1)'(1)) < {1'b0, i_cfg.size[d]})) begin
                is_last = 1'b0;
            end
        end

        // Stale coordinates at or above their extent carry as well
        carry      = 1'b1;
        coord_step = coord_eff;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (carry && (DIM_W'(d) < i_cfg.num_dims)) begin
                if (({1'b0, coord_eff[d]} + (EXT_W + 1)'(1)) >= {1'b0, i_cfg.size[d]}) begin
                    coord_step[d] = '0;
                end else begin
                    coord_step[d] = coord_eff[d] + EXT_W'(1);
                    carry         = 1'b0;
                end
            end
        end

        if (i_cfg.bad) begin
            n_coord = coord_eff;
            n_lin   = lin_eff;
        end else if (is_last) begin
            n_coord = '0;
            n_lin   = '0;
        end else begin
            n_coord = coord_step;
            n_lin   = lin_eff + ADDR_BITS'(1);
        end

        b_next.lin     = lin_eff;
        b_next.stride  = stride_eff;
        b_next.scoord  = coord_eff[i_cfg.shift_axis];
        b_next.sext    = i_cfg.size[i_cfg.shift_axis];
        b_next.unit_ok = unit_ok;
        b_next.bad     = i_cfg.bad;
        b_next.last    = is_last && !i_cfg.bad;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_tbl[r_clr_idx] <= TBL_MISSING;
        end else if (load_fire) begin
            r_tbl[i_head.tindex[TBL_AW-1:0]] <= {i_head.missing, i_head.shift};
        end
        if (step_fire) r_rd <= r_tbl[ucoord[TBL_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_coord    <= '0;
            r_lin      <= '0;
            r_stride   <= ADDR_BITS'(1);
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + TBL_AW'(1);
                if (r_clr_idx == TBL_AW'(SHIFT_DEPTH - 1)) r_clr_busy <= 1'b0;
            end
            if (step_fire) begin
                r_coord  <= n_coord;
                r_lin    <= n_lin;
                r_stride <= stride_eff;
            end
        end
    end

    // Check stage: bounds of the shifted coordinate, shift times stride
    always_comb begin
        missing_b = r_rd[TBL_W-1] || !r_b.unit_ok;
        sh        = $signed(r_rd[SHIFT_W-1:0]);
        nt        = $signed({3'b000, r_b.scoord}) + $signed({{2{sh[SHIFT_W-1]}}, sh});
        in_range  = !nt[EXT_W+2] && (unsigned'(nt) < {3'b000, r_b.sext});
        // Low address bits only: sign-extended shift times stride wraps modulo 2^32
        prod_lo   = r_b.stride * ADDR_BITS'(sh);

        c_next.lin  = r_b.lin;
        c_next.prod = prod_lo;
        c_next.fill = r_b.bad || missing_b || !in_range;
        c_next.bad  = r_b.bad;
        c_next.last = r_b.last;
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) r_b <= b_next;
        if (c_free && r_b_valid) r_c <= c_next;
        if (out_free && r_c_valid) begin
            r_o_index <= r_c.lin;
            r_o_src   <= r_c.fill ? '0 : r_c.lin + r_c.prod;
            r_o_fill  <= r_c.fill;
            r_o_err   <= r_c.bad;
            r_o_last  <= r_c.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (step_fire) r_b_valid <= 1'b1;
            else if (c_free) r_b_valid <= 1'b0;
            if (c_free) r_c_valid <= r_b_valid;
            if (out_free) r_o_valid <= r_c_valid;
        end
    end

    assign o_tbl_busy      = r_clr_busy;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_src, r_o_index};
    assign o_m_axis_tuser  = {r_o_err, r_o_fill};
    assign o_m_axis_tlast  = r_o_last;

endmodule

// File: rtl/core/per_unit_axis_shift_address_gen_core.sv
// Top level of the shifted-gather address generator.
// Walks an array of up to four dimensions in column-major order and gives one
// gather transfer per step item: out_index, source_address, fill, config_error,
// with tlast on the final element. Load items write one shift table entry and
// give no transfer. Sustained rate is one item per clock while the output takes
// results and no table sweep or configuration settling holds the input; a step's
// result passes the table read, the multiply and the output register in turn.
// After reset the shift table is swept to missing, during which no item is
// accepted; configuration writes are taken as ever. Each configuration write
// holds the input off while the stride and the element-count check are recomputed.
module per_unit_axis_shift_address_gen_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // restart[0], table_index[10:1], shift_amount[27:11], shift_missing[28], zero pad
    input  logic [31:0]                   i_s_axis_tdata,
    // kind[0]
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_index[31:0], source_address[63:32]
    output logic [63:0]                   o_m_axis_tdata,
    // fill[0], config_error[1]
    output logic [1:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [pusag_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [pusag_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import pusag_pkg::*;

    t_cfg  cfg;
    t_item head;
    logic  cfg_busy;
    logic  tbl_busy;
    logic  head_valid;
    logic  pop;

    pusag_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_busy      (cfg_busy)
    );

    pusag_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_hold          (cfg_busy || tbl_busy),
        .o_head_valid    (head_valid),
        .o_head          (head),
        .i_pop           (pop)
    );

    pusag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_tbl_busy      (tbl_busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> !o_s_axis_tready)
        else $error("input accepted during table clear");

    a_settle_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_axis_tready)
        else $error("input ready right after a configuration write");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tuser[0] && !o_m_axis_tlast))
        else $error("config error transfer without fill or with last");

    a_fill_zero_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[63:32] == '0))
        else $error("fill transfer with nonzero source address");

endmodule

// File: test/tb.sv
// Self-checking testbench for the shifted-gather address generator core.
`timescale 1ns / 1ps

module tb;
    import pusag_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0]               nd;
        logic [MAX_DIMS-1:0][EXT_W-1:0] sz;
        logic [AX_W-1:0]                sa;
        logic [AX_W-1:0]                ua;
    } t_shape;

    typedef struct packed {
        logic [31:0] out_index;
        logic [31:0] src_addr;
        logic        fill;
        logic        cfg_err;
        logic        last;
    } t_gather;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_tvalid  = 1'b0;
    logic              in_tready;
    // restart[0], table_index[10:1], shift_amount[27:11], shift_missing[28], zero pad
    logic [31:0]       in_tdata   = '0;
    // kind[0]
    logic              in_tuser   = 1'b0;
    logic              out_tvalid;
    logic              out_tready = 1'b0;
    // out_index[31:0], source_address[63:32]
    logic [63:0]       out_tdata;
    // fill[0], config_error[1]
    logic [1:0]        out_tuser;
    logic              out_tlast;
    logic              cfg_we     = 1'b0;
    logic [CFG_AW-1:0] cfg_addr   = '0;
    logic [CFG_DW-1:0] cfg_wdata  = '0;

    // Predictor state: shift table, walk counter and the live register copy
    logic [TBL_W-1:0] shift_mem [SHIFT_DEPTH];
    logic [EXT_W-1:0] walk_coord [MAX_DIMS];
    logic [31:0]      walk_pos;
    logic [31:0]      walk_stride;
    t_shape           geom;

    t_item   item_q [$];
    t_gather expected_q [$];
    t_item   cur_item;

    int items_open = 0;
    int pushed     = 0;
    int errors     = 0;
    int send_wait  = 0;
    int hold_cnt   = 0;
    bit calm       = 1'b0;
    int n_loads = 0, n_steps = 0, n_shapes = 0, n_fill = 0, n_cfg_err = 0, n_last = 0;

    per_unit_axis_shift_address_gen_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tuser  (in_tuser),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tuser  (out_tuser),
        .o_m_axis_tlast  (out_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d items and %0d results outstanding",
                 items_open, expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 48);
    endfunction

    function automatic t_shape make_shape(input int nd, s0, s1, s2, s3, sa, ua);
        t_shape s;
        s.nd    = DIM_W'(nd);
        s.sz[0] = EXT_W'(s0);
        s.sz[1] = EXT_W'(s1);
        s.sz[2] = EXT_W'(s2);
        s.sz[3] = EXT_W'(s3);
        s.sa    = AX_W'(sa);
        s.ua    = AX_W'(ua);
        return s;
    endfunction

    function automatic bit shape_bad(input t_shape s);
        longint unsigned cells;
        cells = 1;
        if (s.nd < 1 || s.nd > MAX_DIMS) return 1'b1;
        if (s.sa >= s.nd || s.ua >= s.nd || s.sa == s.ua) return 1'b1;
        for (int d = 0; d < s.nd; d++) begin
            if (s.sz[d] == 0) return 1'b1;
            cells = cells * s.sz[d];
        end
        return cells > (64'd1 << ADDR_BITS);
    endfunction

    // Advance the predicted walk for one accepted item and queue its result
    task automatic predict_gather(input t_item it);
        t_gather          r;
        logic [TBL_W-1:0] ent;
        longint           sh, nt;
        int unsigned      c;
        if (it.kind == KIND_LOAD) begin
            shift_mem[it.tindex] = {it.missing, it.shift};
            n_loads++;
            return;
        end
        n_steps++;
        if (it.restart) begin
            for (int d = 0; d < MAX_DIMS; d++) walk_coord[d] = '0;
            walk_pos    = '0;
            walk_stride = 32'd1;
            for (int d = 0; d < geom.sa; d++) walk_stride = walk_stride * geom.sz[d];
        end
        r.out_index = walk_pos;
        r.src_addr  = '0;
        r.fill      = 1'b1;
        r.cfg_err   = 1'b0;
        r.last      = 1'b1;
        if (shape_bad(geom)) begin
            // hold the walk where it is
            r.cfg_err = 1'b1;
            r.last    = 1'b0;
        end else begin
            ent = (walk_coord[geom.ua] < SHIFT_DEPTH) ? shift_mem[walk_coord[geom.ua]]
                                                      : TBL_MISSING;
            if (!ent[TBL_W-1]) begin
                sh = $signed(ent[SHIFT_W-1:0]);
                nt = longint'(walk_coord[geom.sa]) + sh;
                if (nt >= 0 && nt < longint'(geom.sz[geom.sa])) begin
                    r.src_addr = walk_pos + 32'(longint'(walk_stride) * sh);
                    r.fill     = 1'b0;
                end
            end
            for (int d = 0; d < geom.nd; d++)
                if (32'(walk_coord[d]) + 32'd1 < 32'(geom.sz[d])) r.last = 1'b0;
            if (r.last) begin
                for (int d = 0; d < MAX_DIMS; d++) walk_coord[d] = '0;
                walk_pos = '0;
            end else begin
                // carry through stale coordinates as well
                for (int d = 0; d < geom.nd; d++) begin
                    c = 32'(walk_coord[d]) + 32'd1;
                    if (c >= geom.sz[d]) begin
                        walk_coord[d] = '0;
                    end else begin
                        walk_coord[d] = EXT_W'(c);
                        break;
                    end
                end
                walk_pos = walk_pos + 32'd1;
            end
        end
        expected_q.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, what, want, got);
            errors++;
        end
    endtask

    task automatic push_load(input logic [IDX_W-1:0] idx, input logic [SHIFT_W-1:0] sh,
                             input logic miss);
        t_item it;
        it.kind    = KIND_LOAD;
        it.restart = 1'($urandom);
        it.tindex  = idx;
        it.shift   = sh;
        it.missing = miss;
        item_q.push_back(it);
        items_open++;
        pushed++;
    endtask

    task automatic push_step(input logic rs);
        t_item it;
        it.kind    = KIND_STEP;
        it.restart = rs;
        it.tindex  = IDX_W'($urandom);
        it.shift   = SHIFT_W'($urandom);
        it.missing = 1'($urandom);
        item_q.push_back(it);
        items_open++;
        pushed++;
    endtask

    task automatic apply_shape(input t_shape s);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_NUM_DIMS;
        cfg_wdata <= CFG_DW'(s.nd);
        for (int d = 0; d < MAX_DIMS; d++) begin
            @(posedge clk);
            cfg_addr  <= CFG_DIM_SIZE_0 + CFG_AW'(d);
            cfg_wdata <= s.sz[d];
        end
        @(posedge clk);
        cfg_addr  <= CFG_SHIFT_AXIS;
        cfg_wdata <= CFG_DW'(s.sa);
        @(posedge clk);
        cfg_addr  <= CFG_UNIT_AXIS;
        cfg_wdata <= CFG_DW'(s.ua);
        @(posedge clk);
        cfg_we <= 1'b0;
        geom = s;
        n_shapes++;
    endtask

    // Wait for every item and result, then let trailing table writes settle
    task automatic drain();
        while (items_open != 0 || expected_q.size() != 0) @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Input side: launch items after random gaps, predict on each transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            in_tvalid <= 1'b0;
        end else begin
            if (in_tvalid && in_tready) begin
                predict_gather(cur_item);
                items_open--;
            end
            if (!in_tvalid || in_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    in_tvalid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    cur_item = item_q.pop_front();
                    in_tvalid <= 1'b1;
                    in_tdata  <= {3'b000, cur_item.missing, cur_item.shift, cur_item.tindex,
                                  cur_item.restart};
                    in_tuser  <= cur_item.kind;
                    send_wait = idle_len();
                end else begin
                    in_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt--;
            out_tready <= 1'b0;
        end else begin
            out_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_cnt = idle_len();
        end
    end

    always @(posedge clk) begin : result_check
        t_gather got, want;
        if (rst_n && out_tvalid && out_tready) begin
            got.out_index = out_tdata[31:0];
            got.src_addr  = out_tdata[63:32];
            got.fill      = out_tuser[0];
            got.cfg_err   = out_tuser[1];
            got.last      = out_tlast;
            n_fill    += got.fill;
            n_cfg_err += got.cfg_err;
            n_last    += got.last;
            if (expected_q.size() == 0) begin
                $display("%0t ns: transfer with nothing expected, expected none, actual 0x%08h",
                         $time, got.out_index);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("out_index", want.out_index, got.out_index);
                check_field("source_address", want.src_addr, got.src_addr);
                check_field("fill", 32'(want.fill), 32'(got.fill));
                check_field("config_error", 32'(want.cfg_err), 32'(got.cfg_err));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin : stimulus
        t_shape          shp;
        t_shape          probe [8];
        longint unsigned cells;
        int unsigned     ext_s, ext_u, nsteps, r;
        logic [SHIFT_W-1:0] sh;

        for (int i = 0; i < SHIFT_DEPTH; i++) shift_mem[i] = TBL_MISSING;
        for (int d = 0; d < MAX_DIMS; d++) walk_coord[d] = '0;
        walk_pos    = '0;
        walk_stride = 32'd1;
        geom = make_shape(2, 1, 1, 1, 1, 1, 0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset shape, single element: missing entry, zero shift, extreme shifts
        push_step(1'b0);
        push_load(10'd0, 17'd0, 1'b0);
        push_step(1'b1);
        push_load(10'd1023, 17'h1FFFF, 1'b1);
        push_load(10'd0, 17'h10000, 1'b0);
        push_step(1'b0);
        drain();

        // Widest extents: large stride, negative and maximum shifts
        apply_shape(make_shape(2, 65535, 65535, 1, 1, 1, 0));
        push_load(10'd0, 17'h0FFFE, 1'b0);
        push_load(10'd1, 17'h1FFFF, 1'b0);
        push_load(10'd2, 17'd0, 1'b1);
        push_load(10'd3, 17'h0FFFF, 1'b0);
        push_step(1'b1);
        push_step(1'b0);
        push_step(1'b0);
        push_step(1'b0);
        drain();

        // Unusable shapes, then exactly 2^32 elements
        probe[0] = make_shape(0, 3, 3, 1, 1, 1, 0);
        probe[1] = make_shape(7, 3, 3, 1, 1, 1, 0);
        probe[2] = make_shape(3, 4, 4, 4, 1, 2, 2);
        probe[3] = make_shape(3, 4, 4, 4, 1, 3, 0);
        probe[4] = make_shape(2, 4, 4, 4, 1, 0, 2);
        probe[5] = make_shape(4, 4, 0, 4, 4, 1, 0);
        probe[6] = make_shape(4, 256, 256, 256, 257, 3, 0);
        probe[7] = make_shape(4, 256, 256, 256, 256, 3, 0);
        for (int i = 0; i < 8; i++) begin
            apply_shape(probe[i]);
            if (i == 7) push_load(10'd0, 17'd1, 1'b0);
            push_step(1'b0);
            push_step(1'b1);
            drain();
        end

        // Long walk so the unit coordinate runs past the end of the table
        apply_shape(make_shape(2, 1030, 2, 1, 1, 1, 0));
        for (int i = 1016; i < SHIFT_DEPTH; i++)
            push_load(IDX_W'(i), SHIFT_W'(int'($urandom_range(0, 2)) - 1),
                      $urandom_range(0, 7) == 0);
        for (int i = 0; i < 24; i++)
            push_load(IDX_W'($urandom), SHIFT_W'(int'($urandom_range(0, 2)) - 1),
                      $urandom_range(0, 7) == 0);
        push_step(1'b1);
        for (int i = 0; i < 1025; i++) push_step(1'b0);
        drain();

        // Random shapes, table contents and walks up to the item budget
        shp = geom;
        while (pushed < 1150) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 6) != 0) begin
                    shp.nd = DIM_W'($urandom_range(2, MAX_DIMS));
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        r = $urandom_range(0, 99);
                        shp.sz[d] = (r < 65) ? EXT_W'($urandom_range(1, 4)) :
                                    (r < 90) ? EXT_W'($urandom_range(5, 12)) :
                                               EXT_W'($urandom_range(1, 65535));
                    end
                    shp.sa = AX_W'($urandom_range(0, shp.nd - 1));
                    shp.ua = AX_W'((shp.sa + $urandom_range(1, shp.nd - 1)) % shp.nd);
                end else begin
                    shp.nd = DIM_W'($urandom);
                    for (int d = 0; d < MAX_DIMS; d++)
                        shp.sz[d] = ($urandom_range(0, 3) == 0) ? '0
                                                                : EXT_W'($urandom_range(1, 8));
                    shp.sa = AX_W'($urandom);
                    shp.ua = AX_W'($urandom);
                end
                apply_shape(shp);
            end

            ext_s = geom.sz[geom.sa];
            ext_u = (geom.sz[geom.ua] > 24) ? 24 : geom.sz[geom.ua];
            for (int i = 0; i < ext_u; i++) begin
                if ($urandom_range(0, 5) != 0) begin
                    sh = ($urandom_range(0, 9) == 0) ? SHIFT_W'($urandom)
                         : SHIFT_W'(int'($urandom_range(0, 2 * ext_s + 2)) - int'(ext_s) - 1);
                    push_load(IDX_W'(i), sh, $urandom_range(0, 7) == 0);
                end
            end
            if ($urandom_range(0, 2) == 0)
                push_load(IDX_W'($urandom), SHIFT_W'($urandom), 1'($urandom));

            cells = 0;
            if (geom.nd >= 1 && geom.nd <= MAX_DIMS) begin
                cells = 1;
                for (int d = 0; d < geom.nd; d++) cells = cells * geom.sz[d];
            end
            nsteps = (cells != 0 && cells <= 30) ? 32'(cells) + $urandom_range(0, 32'(cells))
                                                 : $urandom_range(6, 30);
            push_step($urandom_range(0, 9) < 6);
            for (int i = 1; i < nsteps; i++) begin
                if ($urandom_range(0, 99) < 8)
                    push_load(IDX_W'($urandom_range(0, 15)), SHIFT_W'($urandom), 1'($urandom));
                push_step($urandom_range(0, 99) < 3);
            end
            drain();
        end

        $display("Covered %0d step and %0d load transfers over %0d register settings",
                 n_steps, n_loads, n_shapes);
        $display("Results: %0d fill, %0d config error, %0d end of array",
                 n_fill, n_cfg_err, n_last);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
